### rtl/ctls_pkg.sv
// Package: shared types, codes and helper functions of the token scanner.
`timescale 1ns / 1ps

package ctls_pkg;

    // Default sizing of the scanner
    localparam int OFFSET_BITS_DEF  = 16;
    localparam int PREFIX_BYTES_DEF = 6;

    // Record field widths
    localparam int KIND_W = 6;
    localparam int POS_W  = 16;
    localparam int BYTE_W = 8;
    localparam int RECS   = 3;

    localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_EOF     = 6'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_INT     = 6'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT   = 6'd3;
    localparam logic [KIND_W-1:0] KIND_CHAR    = 6'd4;
    localparam logic [KIND_W-1:0] KIND_KW0     = 6'd5;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd16;
    localparam logic [KIND_W-1:0] KIND_EQ      = 6'd17;
    localparam logic [KIND_W-1:0] KIND_NOT     = 6'd18;
    localparam logic [KIND_W-1:0] KIND_NE      = 6'd19;
    localparam logic [KIND_W-1:0] KIND_LT      = 6'd20;
    localparam logic [KIND_W-1:0] KIND_LE      = 6'd21;
    localparam logic [KIND_W-1:0] KIND_GT      = 6'd22;
    localparam logic [KIND_W-1:0] KIND_GE      = 6'd23;
    localparam logic [KIND_W-1:0] KIND_LAND    = 6'd24;
    localparam logic [KIND_W-1:0] KIND_LOR     = 6'd25;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd26;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd27;
    localparam logic [KIND_W-1:0] KIND_STAR    = 6'd28;
    localparam logic [KIND_W-1:0] KIND_DIV     = 6'd29;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd30;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd31;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd32;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd33;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd34;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd35;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords, packed first byte lowest, with their lengths
    localparam int KW_COUNT = 11;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0000_6C6F_6F62,   // bool
        64'h0000_0000_7261_6863,   // char
        64'h0000_0074_616F_6C66,   // float
        64'h0000_0000_6575_7274,   // true
        64'h0000_0065_736C_6166,   // false
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6573_6C65,   // else
        64'h0000_0065_6C69_6877,   // while
        64'h0000_0000_0072_6F66,   // for
        64'h0000_6E72_7574_6572    // return
    };
    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        16'd3, 16'd4, 16'd4, 16'd5, 16'd4, 16'd5, 16'd2, 16'd4, 16'd5, 16'd3, 16'd6
    };

    // Scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FLOAT,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR,
        MODE_QOPEN,
        MODE_QBODY,
        MODE_OP
    } scan_mode_t;

    // One token record
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  len;
        logic [BYTE_W-1:0] lit;
    } rec_t;

    // Records caused by one text word, oldest in slot 0
    typedef struct packed {
        rec_t [RECS-1:0] slot;
        logic [1:0]      count;
    } rec_group_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT)
            || (c == CH_AMP) || (c == CH_BAR);
    endfunction

    // Kind of a byte that forms a whole token by itself from idle
    function automatic logic [KIND_W-1:0] idle_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Kind of a held operator byte that did not pair up
    function automatic logic [KIND_W-1:0] single_op_kind(input logic [7:0] h);
        logic [KIND_W-1:0] k;
        case (h)
            CH_EQ:   k = KIND_ASSIGN;
            CH_BANG: k = KIND_NOT;
            CH_LT:   k = KIND_LT;
            CH_GT:   k = KIND_GT;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Identifier or keyword, from the captured prefix and the full length
    function automatic logic [KIND_W-1:0] word_kind(input logic [63:0] prefix,
                                                    input logic [POS_W-1:0] len);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                k = KIND_KW0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

endpackage

### rtl/ctls_in_if.sv
// Interface: text channel, one source byte per word.
`timescale 1ns / 1ps

interface ctls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

### rtl/ctls_out_if.sv
// Interface: token channel, one token record per word.
`timescale 1ns / 1ps

interface ctls_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  literal_byte;
    logic        run_end;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output literal_byte, output run_end,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input literal_byte, input run_end,
                    output ready);
endinterface

### rtl/ctls_scan_core.sv
// Scanner state and the per-byte token record logic.
`timescale 1ns / 1ps

module ctls_scan_core #(
    parameter int OFFSET_BITS  = ctls_pkg::OFFSET_BITS_DEF,
    parameter int PREFIX_BYTES = ctls_pkg::PREFIX_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             text_byte,
    input  logic                   final_byte,
    output ctls_pkg::rec_group_t   grp
);

    localparam int PREFIX_W = 8 * PREFIX_BYTES;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    ctls_pkg::scan_mode_t           mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]         offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]         start_reg, start_next;
    logic [ctls_pkg::POS_W-1:0]     length_reg, length_next;
    logic [PREFIX_W-1:0]            prefix_reg, prefix_next;
    logic [7:0]                     held_reg, held_next;
    logic                           done_reg, done_next;

    function automatic logic [ctls_pkg::POS_W-1:0] clip_pos(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? ctls_pkg::POS_MAX : w[15:0];
    endfunction

    function automatic ctls_pkg::rec_t mk_rec(input logic [ctls_pkg::KIND_W-1:0] kind,
                                              input logic [OFFSET_BITS-1:0] start,
                                              input logic [ctls_pkg::POS_W-1:0] len,
                                              input logic [7:0] lit);
        ctls_pkg::rec_t r;
        r.kind  = kind;
        r.start = clip_pos(start);
        r.len   = len;
        r.lit   = lit;
        return r;
    endfunction

    function automatic logic [ctls_pkg::POS_W-1:0] len_inc(input logic [ctls_pkg::POS_W-1:0] l);
        return (l != ctls_pkg::POS_MAX) ? l + 16'd1 : l;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic       redo;
        logic       pair;
        logic [1:0] n;
        logic [ctls_pkg::KIND_W-1:0] pk;

        c           = text_byte;
        redo        = 1'b0;
        pair        = 1'b0;
        n           = 2'd0;
        pk          = ctls_pkg::KIND_UNKNOWN;
        mode_next   = mode_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        length_next = length_reg;
        prefix_next = prefix_reg;
        held_next   = held_reg;
        done_next   = done_reg;
        grp         = '0;

        if (fire && !done_reg) begin
            if (c != ctls_pkg::CH_NUL) begin
                // close or extend the open token
                case (mode_reg)
                    ctls_pkg::MODE_IDENT:
                    begin
                        if (ctls_pkg::is_alpha(c) || ctls_pkg::is_digit(c)) begin
                            for (int i = 0; i < PREFIX_BYTES; i++) begin
                                if (length_reg == 16'(i)) begin
                                    prefix_next[8*i +: 8] = c;
                                end
                            end
                            length_next = len_inc(length_reg);
                        end else begin
                            grp.slot[n] = mk_rec(ctls_pkg::word_kind(64'(prefix_reg), length_reg),
                                                 start_reg, length_reg, 8'd0);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    ctls_pkg::MODE_INT:
                    begin
                        if (ctls_pkg::is_digit(c)) begin
                            length_next = len_inc(length_reg);
                        end else if (c == ctls_pkg::CH_DOT) begin
                            length_next = len_inc(length_reg);
                            mode_next   = ctls_pkg::MODE_FLOAT;
                        end else begin
                            grp.slot[n] = mk_rec(ctls_pkg::KIND_INT, start_reg, length_reg, 8'd0);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    ctls_pkg::MODE_FLOAT:
                    begin
                        if (ctls_pkg::is_digit(c)) begin
                            length_next = len_inc(length_reg);
                        end else begin
                            grp.slot[n] = mk_rec(ctls_pkg::KIND_FLOAT, start_reg, length_reg,
                                                 8'd0);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    ctls_pkg::MODE_SLASH:
                    begin
                        if (c == ctls_pkg::CH_SLASH) begin
                            mode_next = ctls_pkg::MODE_LINE;
                        end else if (c == ctls_pkg::CH_STAR) begin
                            mode_next = ctls_pkg::MODE_BLOCK;
                        end else begin
                            grp.slot[n] = mk_rec(ctls_pkg::KIND_DIV, start_reg, 16'd1, 8'd0);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    ctls_pkg::MODE_LINE:
                    begin
                        if (c == ctls_pkg::CH_LF) begin
                            mode_next = ctls_pkg::MODE_IDLE;
                        end
                    end
                    ctls_pkg::MODE_BLOCK:
                    begin
                        if (c == ctls_pkg::CH_STAR) begin
                            mode_next = ctls_pkg::MODE_BSTAR;
                        end
                    end
                    ctls_pkg::MODE_BSTAR:
                    begin
                        if (c == ctls_pkg::CH_SLASH) begin
                            mode_next = ctls_pkg::MODE_IDLE;
                        end else if (c != ctls_pkg::CH_STAR) begin
                            mode_next = ctls_pkg::MODE_BLOCK;
                        end
                    end
                    ctls_pkg::MODE_QOPEN:
                    begin
                        held_next   = c;
                        length_next = len_inc(length_reg);
                        mode_next   = ctls_pkg::MODE_QBODY;
                    end
                    ctls_pkg::MODE_QBODY:
                    begin
                        // closing byte is taken as is
                        grp.slot[n] = mk_rec(ctls_pkg::KIND_CHAR, start_reg, 16'd3, held_reg);
                        n = n + 2'd1;
                        mode_next = ctls_pkg::MODE_IDLE;
                    end
                    ctls_pkg::MODE_OP:
                    begin
                        case (held_reg)
                            ctls_pkg::CH_EQ:   pk = ctls_pkg::KIND_EQ;
                            ctls_pkg::CH_BANG: pk = ctls_pkg::KIND_NE;
                            ctls_pkg::CH_LT:   pk = ctls_pkg::KIND_LE;
                            ctls_pkg::CH_GT:   pk = ctls_pkg::KIND_GE;
                            ctls_pkg::CH_AMP:  pk = ctls_pkg::KIND_LAND;
                            ctls_pkg::CH_BAR:  pk = ctls_pkg::KIND_LOR;
                            default:           pk = ctls_pkg::KIND_UNKNOWN;
                        endcase
                        pair = ((c == ctls_pkg::CH_EQ) && (held_reg == ctls_pkg::CH_EQ
                                 || held_reg == ctls_pkg::CH_BANG || held_reg == ctls_pkg::CH_LT
                                 || held_reg == ctls_pkg::CH_GT))
                            || (c == ctls_pkg::CH_AMP && held_reg == ctls_pkg::CH_AMP)
                            || (c == ctls_pkg::CH_BAR && held_reg == ctls_pkg::CH_BAR);
                        if (pair) begin
                            grp.slot[n] = mk_rec(pk, start_reg, 16'd2, 8'd0);
                            n = n + 2'd1;
                            mode_next = ctls_pkg::MODE_IDLE;
                        end else begin
                            grp.slot[n] = mk_rec(ctls_pkg::single_op_kind(held_reg), start_reg,
                                                 16'd1, 8'd0);
                            n = n + 2'd1;
                            redo = 1'b1;
                        end
                    end
                    default:
                    begin
                        redo = 1'b1;
                    end
                endcase

                // rescan the byte from idle
                if (redo) begin
                    mode_next = ctls_pkg::MODE_IDLE;
                    if (ctls_pkg::is_space(c)) begin
                        mode_next = ctls_pkg::MODE_IDLE;
                    end else if (ctls_pkg::is_alpha(c) || ctls_pkg::is_digit(c)
                                 || c == ctls_pkg::CH_QUOTE || c == ctls_pkg::CH_SLASH
                                 || ctls_pkg::is_op_start(c)) begin
                        start_next  = offset_reg;
                        length_next = 16'd1;
                        prefix_next = '0;
                        held_next   = 8'd0;
                        if (ctls_pkg::is_alpha(c)) begin
                            mode_next   = ctls_pkg::MODE_IDENT;
                            prefix_next = PREFIX_W'(c);
                        end else if (ctls_pkg::is_digit(c)) begin
                            mode_next = ctls_pkg::MODE_INT;
                        end else if (c == ctls_pkg::CH_QUOTE) begin
                            mode_next = ctls_pkg::MODE_QOPEN;
                        end else if (c == ctls_pkg::CH_SLASH) begin
                            mode_next = ctls_pkg::MODE_SLASH;
                        end else begin
                            mode_next = ctls_pkg::MODE_OP;
                            held_next = c;
                        end
                    end else begin
                        grp.slot[n] = mk_rec(ctls_pkg::idle_kind(c), offset_reg, 16'd1, 8'd0);
                        n = n + 2'd1;
                    end
                end

                if (offset_reg != OFF_MAX) begin
                    offset_next = offset_reg + OFFSET_BITS'(1);
                end
            end

            // end of text: flush the open token, then the end record
            if (c == ctls_pkg::CH_NUL || final_byte) begin
                case (mode_next)
                    ctls_pkg::MODE_IDENT:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::word_kind(64'(prefix_next), length_next),
                                             start_next, length_next, 8'd0);
                        n = n + 2'd1;
                    end
                    ctls_pkg::MODE_INT:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::KIND_INT, start_next, length_next, 8'd0);
                        n = n + 2'd1;
                    end
                    ctls_pkg::MODE_FLOAT:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::KIND_FLOAT, start_next, length_next, 8'd0);
                        n = n + 2'd1;
                    end
                    ctls_pkg::MODE_SLASH:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::KIND_DIV, start_next, 16'd1, 8'd0);
                        n = n + 2'd1;
                    end
                    ctls_pkg::MODE_QOPEN, ctls_pkg::MODE_QBODY:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::KIND_UNKNOWN, start_next, length_next,
                                             8'd0);
                        n = n + 2'd1;
                    end
                    ctls_pkg::MODE_OP:
                    begin
                        grp.slot[n] = mk_rec(ctls_pkg::single_op_kind(held_next), start_next,
                                             16'd1, 8'd0);
                        n = n + 2'd1;
                    end
                    default:
                    begin
                        n = n;
                    end
                endcase
                mode_next = ctls_pkg::MODE_IDLE;
                grp.slot[n] = mk_rec(ctls_pkg::KIND_EOF, offset_next, 16'd0, 8'd0);
                n = n + 2'd1;
                done_next = 1'b1;
            end
        end
        grp.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= ctls_pkg::MODE_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            length_reg <= '0;
            prefix_reg <= '0;
            held_reg   <= '0;
            done_reg   <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            length_reg <= length_next;
            prefix_reg <= prefix_next;
            held_reg   <= held_next;
            done_reg   <= done_next;
        end
    end

    // End of text is sticky until reset.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("end-of-text flag cleared without reset");

    // A zero or last byte always closes the text and produces a record.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !done_reg && (text_byte == ctls_pkg::CH_NUL || final_byte))
            |-> (grp.count != 2'd0) ##1 done_reg)
        else $error("end of text did not close the scan");

    // Nothing is produced once the text has ended.
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (grp.count == 2'd0 && mode_reg == ctls_pkg::MODE_IDLE))
        else $error("record produced after end of text");

endmodule

### rtl/ctls_rec_buf.sv
// Result register: holds the records of one byte and hands them out in order.
`timescale 1ns / 1ps

module ctls_rec_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  ctls_pkg::rec_group_t  grp,
    output logic                  free,
    ctls_out_if.source            tokens
);

    ctls_pkg::rec_group_t grp_reg, grp_next;
    logic [1:0]           count_reg, count_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 last;
    logic                 take;
    ctls_pkg::rec_t       cur;

    assign last = (count_reg != 2'd0) && (idx_reg == count_reg - 2'd1);
    assign take = tokens.valid && tokens.ready;
    assign free = (count_reg == 2'd0) || (last && tokens.ready);
    assign cur  = grp_reg.slot[idx_reg];

    assign tokens.valid        = (count_reg != 2'd0);
    assign tokens.token_kind   = cur.kind;
    assign tokens.start_offset = cur.start;
    assign tokens.token_length = cur.len;
    assign tokens.literal_byte = cur.lit;
    assign tokens.run_end      = last;

    always_comb
    begin
        grp_next   = grp_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load && grp.count != 2'd0) begin
            grp_next   = grp;
            count_next = grp.count;
            idx_next   = 2'd0;
        end else if (take) begin
            if (last) begin
                count_next = 2'd0;
                idx_next   = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    // The read index stays inside the loaded group.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd0) |-> (idx_reg < count_reg))
        else $error("record index beyond loaded group");

    // A load never lands on records still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && grp.count != 2'd0) |-> free)
        else $error("records overwritten before delivery");

    // A stalled word advances nowhere.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && !tokens.ready) |=> ($stable(idx_reg) && $stable(count_reg)))
        else $error("record index moved while stalled");

endmodule

### rtl/c_like_token_scanner.sv
// Top level: streaming token scanner for a small C-like language.
`timescale 1ns / 1ps

// Usage
//   text   : one source byte per word (text_byte, final_byte). A zero byte or a
//            word with final_byte set ends the text.
//   tokens : one token record per word (kind, start offset, length, quoted
//            byte of a char literal, run_end on the last record of a byte).
// Each text word first lands in an input register; once the result register
// is free, the scan logic updates the scanner state and loads the records
// caused by that byte (zero to three) into the result register, from which
// the first record of the byte is offered.
// Throughput: one byte per cycle while each byte causes at most one record
// and tokens does not stall; a byte that causes more records holds the path
// until the single record port of the result register has handed them out.
// When tokens stalls, the result register holds its record, the input
// register keeps one more byte, and then text ready drops.
// After the end of the text, further bytes are taken and dropped until reset.
// Reset clears the scanner to idle at offset zero and empties both registers.
module c_like_token_scanner #(
    parameter int OFFSET_BITS  = ctls_pkg::OFFSET_BITS_DEF,
    parameter int PREFIX_BYTES = ctls_pkg::PREFIX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ctls_in_if.sink     text,
    ctls_out_if.source  tokens
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       final_reg, final_next;

    logic                 buf_free;
    logic                 fire;
    ctls_pkg::rec_group_t grp;

    // Advance the held byte whenever the result register can take its records.
    assign fire       = in_valid_reg && buf_free;
    assign text.ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        final_next    = final_reg;
        if (text.valid && text.ready) begin
            in_valid_next = 1'b1;
            byte_next     = text.text_byte;
            final_next    = text.final_byte;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        final_reg <= final_next;
    end

    ctls_scan_core #(
        .OFFSET_BITS  (OFFSET_BITS),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .text_byte  (byte_reg),
        .final_byte (final_reg),
        .grp        (grp)
    );

    ctls_rec_buf u_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire),
        .grp    (grp),
        .free   (buf_free),
        .tokens (tokens)
    );

    // A held byte with room downstream moves on in the same cycle.
    a_fire_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !(text.valid && text.ready)) |=> !in_valid_reg)
        else $error("held byte not released after advance");

endmodule
